>>> rtl/tss_pkg.sv
// Package for the two-stack sorter: payload structs and sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package tss_pkg;

    localparam int TSS_DEPTH = 64;
    localparam int DATA_W    = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic                     last_res;
        logic                     overflow;
    } out_t;

endpackage

>>> rtl/tss_stack_ram.sv
// Stack storage: one write port, one read port, registered read data.
// Depends on tss_pkg.
`timescale 1ns / 1ps

module tss_stack_ram
    import tss_pkg::*;
#(
    parameter int DEPTH = TSS_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic signed [DATA_W-1:0] wdata,
    input  logic                     re,
    input  logic [AW-1:0]            raddr,
    output logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tss_ctrl.sv
// Sequencer for the two-stack sorter: push, insertion sort through the
// temporary stack, emission through the output register. Depends on tss_pkg.
`timescale 1ns / 1ps

module tss_ctrl
    import tss_pkg::*;
#(
    parameter int DEPTH = TSS_DEPTH,
    localparam int AW = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_t                      s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_t                     m_data,
    output logic                     main_we,
    output logic [AW-1:0]            main_waddr,
    output logic signed [DATA_W-1:0] main_wdata,
    output logic                     main_re,
    output logic [AW-1:0]            main_raddr,
    input  logic signed [DATA_W-1:0] main_rdata,
    output logic                     temp_we,
    output logic [AW-1:0]            temp_waddr,
    output logic signed [DATA_W-1:0] temp_wdata,
    output logic                     temp_re,
    output logic [AW-1:0]            temp_raddr,
    input  logic signed [DATA_W-1:0] temp_rdata
);

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_POP  = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_ERD  = 3'd3;
    localparam logic [2:0] ST_EOUT = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] main_cnt_reg, main_cnt_next;
    logic [CNT_W-1:0] temp_cnt_reg, temp_cnt_next;
    logic             dropped_reg, dropped_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg, m_data_next;

    logic [CNT_W-1:0] main_cnt_m1, temp_cnt_m1, temp_cnt_m2;
    logic             is_last_out;

    assign main_cnt_m1 = main_cnt_reg - CNT_W'(1);
    assign temp_cnt_m1 = temp_cnt_reg - CNT_W'(1);
    assign temp_cnt_m2 = temp_cnt_reg - CNT_W'(2);
    assign is_last_out = (main_cnt_reg == temp_cnt_m1);

    always_comb begin
        state_next    = state_reg;
        main_cnt_next = main_cnt_reg;
        temp_cnt_next = temp_cnt_reg;
        dropped_next  = dropped_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        s_ready       = 1'b0;
        main_we       = 1'b0;
        main_waddr    = main_cnt_reg[AW-1:0];
        main_wdata    = temp_rdata;
        main_re       = 1'b0;
        main_raddr    = main_cnt_m1[AW-1:0];
        temp_we       = 1'b0;
        temp_waddr    = temp_cnt_reg[AW-1:0];
        temp_wdata    = main_rdata;
        temp_re       = 1'b0;
        temp_raddr    = temp_cnt_m1[AW-1:0];

        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (main_cnt_reg < CNT_W'(DEPTH)) begin
                        main_we       = 1'b1;
                        main_wdata    = s_data.value;
                        main_cnt_next = main_cnt_reg + CNT_W'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_data.last) begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP: begin
                if (main_cnt_reg == '0) begin
                    state_next = ST_ERD;
                end else begin
                    main_re       = 1'b1;
                    temp_re       = 1'b1;
                    main_cnt_next = main_cnt_m1;
                    state_next    = ST_CMP;
                end
            end
            ST_CMP: begin
                // main_rdata holds the popped value, temp_rdata the temp top
                if (temp_cnt_reg != '0 && temp_rdata > main_rdata) begin
                    main_we       = 1'b1;
                    main_cnt_next = main_cnt_reg + CNT_W'(1);
                    temp_cnt_next = temp_cnt_m1;
                    temp_re       = 1'b1;
                    temp_raddr    = temp_cnt_m2[AW-1:0];
                end else begin
                    temp_we       = 1'b1;
                    temp_cnt_next = temp_cnt_reg + CNT_W'(1);
                    state_next    = ST_POP;
                end
            end
            ST_ERD: begin
                // temp stack is ascending from the bottom; main count indexes it
                temp_re    = 1'b1;
                temp_raddr = main_cnt_reg[AW-1:0];
                state_next = ST_EOUT;
            end
            ST_EOUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.value_res = temp_rdata;
                    m_data_next.last_res  = is_last_out;
                    m_data_next.overflow  = dropped_reg;
                    if (is_last_out) begin
                        main_cnt_next = '0;
                        temp_cnt_next = '0;
                        dropped_next  = 1'b0;
                        state_next    = ST_LOAD;
                    end else begin
                        main_cnt_next = main_cnt_reg + CNT_W'(1);
                        state_next    = ST_ERD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            main_cnt_reg <= '0;
            temp_cnt_reg <= '0;
            dropped_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            main_cnt_reg <= main_cnt_next;
            temp_cnt_reg <= temp_cnt_next;
            dropped_reg  <= dropped_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/two_stack_sorter_unit.sv
// Two-stack sorter top level: two stack memories and the sequencer.
// Depends on tss_pkg, tss_stack_ram, tss_ctrl.
//
//   channel | ports                      | transfer carries
//   --------+----------------------------+--------------------------------
//   input   | s_valid, s_ready, s_data   | value, last
//   result  | m_valid, m_ready, m_data   | value_res, last_res, overflow
//
// Push: one input transfer per cycle while loading. On a last transfer the batch
// is sorted: each popped value moves greater temp entries back to main, then goes
// onto temp; ascending arrival gives the most moves, bound by the single read port
// of each stack. Emission: each result is read, then loaded into the output register.
// Reset clears counts and the output valid flag; output data and stack contents need
// no clearing. Input is stalled from the last transfer until the final result is loaded.
`timescale 1ns / 1ps

module two_stack_sorter_unit
    import tss_pkg::*;
#(
    parameter int DEPTH = TSS_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int AW = $clog2(DEPTH);

    logic                     main_we, main_re, temp_we, temp_re;
    logic [AW-1:0]            main_waddr, main_raddr, temp_waddr, temp_raddr;
    logic signed [DATA_W-1:0] main_wdata, main_rdata, temp_wdata, temp_rdata;

    tss_stack_ram #(.DEPTH(DEPTH)) u_main_ram (
        .aclk  (aclk),
        .we    (main_we),
        .waddr (main_waddr),
        .wdata (main_wdata),
        .re    (main_re),
        .raddr (main_raddr),
        .rdata (main_rdata)
    );

    tss_stack_ram #(.DEPTH(DEPTH)) u_temp_ram (
        .aclk  (aclk),
        .we    (temp_we),
        .waddr (temp_waddr),
        .wdata (temp_wdata),
        .re    (temp_re),
        .raddr (temp_raddr),
        .rdata (temp_rdata)
    );

    tss_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .main_we    (main_we),
        .main_waddr (main_waddr),
        .main_wdata (main_wdata),
        .main_re    (main_re),
        .main_raddr (main_raddr),
        .main_rdata (main_rdata),
        .temp_we    (temp_we),
        .temp_waddr (temp_waddr),
        .temp_wdata (temp_wdata),
        .temp_re    (temp_re),
        .temp_raddr (temp_raddr),
        .temp_rdata (temp_rdata)
    );

endmodule

>>> rtl/tss_checker.sv
// Port-level checks for the two-stack sorter, bound to the top level.
// Depends on tss_pkg and two_stack_sorter_unit.
`timescale 1ns / 1ps

module tss_checker
    import tss_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_sort_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last |=> !s_ready)
        else $error("input taken right after last transfer");

    a_emit_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last_res |-> !s_ready)
        else $error("input taken during emission");

    a_batch_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last_res |=> !m_valid)
        else $error("result after final transfer of batch");

endmodule

bind two_stack_sorter_unit tss_checker u_tss_checker (.*);
